/* src/view_ray_ellipsoid_intersect_assert.svh */
// ----------------------------------------------------------------------------
// view_ray_ellipsoid_intersect_assert.svh
// Assertion macros shared by the ray/ellipsoid block.
// ----------------------------------------------------------------------------
`ifndef VIEW_RAY_ELLIPSOID_INTERSECT_ASSERT_SVH
`define VIEW_RAY_ELLIPSOID_INTERSECT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VREI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vrei assertion failed");

// antecedent implies consequent in the next cycle
`define VREI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrei assertion failed");

`endif

/* src/vrei_pkg.sv */
// ----------------------------------------------------------------------------
// vrei_pkg
// Types, codes and helpers for the ray/ellipsoid intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package vrei_pkg;

  localparam int unsigned FieldWidth = 34;
  localparam int unsigned ScaleShift = 22;
  localparam int unsigned Q30        = 30;

  // commands
  localparam logic [1:0] CMD_POS  = 2'd0;
  localparam logic [1:0] CMD_ROW  = 2'd1;
  localparam logic [1:0] CMD_VIEW = 2'd2;

  // result status
  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_NOHIT   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_EQ_RADIUS  = 2'd0;
  localparam logic [1:0] REG_POL_RADIUS = 2'd1;
  localparam logic [1:0] REG_THRESHOLD  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_LAUNCH, S_MUL, S_DIV, S_ROUND, S_POST, S_SQRT, S_SQEND, S_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_MV, OP_PS, OP_US, OP_PP, OP_UP, OP_UU, OP_S1, OP_S2, OP_D, OP_W
  } op_e;

  // strictly inside (-2^62, 2^62)
  function automatic logic lim_ok(input logic signed [63:0] x);
    return (x[63:62] == 2'b00) || ((x[63:62] == 2'b11) && (x[61:0] != '0));
  endfunction

  // x representable as a w bit signed value
  function automatic logic fits_w(input logic signed [63:0] x, input int unsigned w);
    logic signed [63:0] h;
    h = 64'sd1 <<< (w - 1);
    return (x >= -h) && (x < h);
  endfunction

endpackage

`default_nettype wire

/* src/view_ray_ellipsoid_intersect.sv */
// ----------------------------------------------------------------------------
// view_ray_ellipsoid_intersect
// Rotates a detector view vector to the Earth-fixed frame and finds the
// nearest hit of the view ray on the Earth ellipsoid.
// ----------------------------------------------------------------------------
// Position and matrix-row loads are registered directly. A detector item runs
// through one shared multiply/divide unit under a sequencer: each operation
// takes a multiply built from 32x32 partial products, then either a shift or a
// 128-step restoring divide, plus round and accumulate cycles; the square root
// runs 32 steps. The six divisions by a radius and the final divide by UU
// dominate the work of a detector item (less when it ends early as invalid or
// no hit). The input is not ready while an item is in work.
`default_nettype none

module view_ray_ellipsoid_intersect
  import vrei_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH      = 34,
  parameter int unsigned DIRECTION_FRAC_BITS = 30
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [33:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          cmd_i,
  input  wire logic [1:0]          row_i,
  input  wire logic signed [33:0]  val_x_i,
  input  wire logic signed [33:0]  val_y_i,
  input  wire logic signed [33:0]  val_z_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               status_o,
  output logic signed [33:0]       view_x_o,
  output logic signed [33:0]       view_y_o,
  output logic signed [33:0]       view_z_o,
  output logic signed [33:0]       ground_x_o,
  output logic signed [33:0]       ground_y_o,
  output logic signed [33:0]       ground_z_o
);

  localparam int unsigned Pw = POSITION_WIDTH;
  localparam int unsigned Fb = DIRECTION_FRAC_BITS;
  localparam logic signed [63:0] ScaleOne = 64'sd1 <<< ScaleShift;
  localparam logic signed [63:0] QOne     = 64'sd1 <<< Q30;
  localparam logic signed [63:0] DScale   = 64'sd1 <<< (Fb + Q30);

  // configuration
  logic [22:0]        equ_q, pol_q;
  logic signed [33:0] thr_q;

  // sample state
  logic signed [Pw-1:0] pos_q [3];
  logic signed [31:0]   rot_q [3][3];
  logic                 sinv_q;

  // item state
  state_e             state_q, state_d;
  op_e                op_q;
  logic [1:0]         i_q, j_q;
  logic signed [33:0] u_q [3];
  logic signed [63:0] v_q [3], ps_q [3], us_q [3];
  logic signed [63:0] pp_q, up_q, uu_q, t_q, d_q, res_q;
  logic [33:0]        w_q [3], g_q [3];
  logic [1:0]         fin_st_q;

  // shared unit
  logic [63:0]  ma_q, mb_q, den_q, rem_q, sqr_q, sqb_q;
  logic [127:0] prod_q;
  logic         neg_q, gen_q;
  logic [6:0]   cnt_q;

  // output register
  logic               out_valid_q;
  logic [1:0]         out_st_q;
  logic signed [33:0] out_v_q [3], out_g_q [3];

  logic in_fire, out_free;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // ---------------- operand select ----------------
  logic signed [63:0] a_sel, b_sel, pm, nval, abs_a, abs_b;
  logic [63:0]        rad64, den_sel;
  logic               gen_sel, launch_bad;

  assign rad64 = {41'd0, (i_q == 2'd2) ? pol_q : equ_q};
  assign pm    = pp_q - QOne;
  assign nval  = -up_q - $signed(sqr_q);

  always_comb begin
    a_sel      = '0;
    b_sel      = '0;
    den_sel    = rad64;
    gen_sel    = 1'b0;
    launch_bad = 1'b0;
    unique case (op_q)
      OP_MV: begin
        a_sel = 64'(rot_q[i_q][j_q]);
        b_sel = 64'(u_q[j_q]);
      end
      OP_PS: begin
        a_sel = 64'(pos_q[i_q]); b_sel = ScaleOne;
        gen_sel = 1'b1; launch_bad = (rad64 == '0);
      end
      OP_US: begin
        a_sel = v_q[i_q]; b_sel = ScaleOne;
        gen_sel = 1'b1; launch_bad = (rad64 == '0);
      end
      OP_PP: begin a_sel = ps_q[i_q]; b_sel = ps_q[i_q]; end
      OP_UP: begin a_sel = us_q[i_q]; b_sel = ps_q[i_q]; end
      OP_UU: begin a_sel = us_q[i_q]; b_sel = us_q[i_q]; end
      OP_S1: begin a_sel = up_q; b_sel = up_q; end
      OP_S2: begin a_sel = uu_q; b_sel = pm; launch_bad = !lim_ok(pm); end
      OP_D: begin
        a_sel = nval; b_sel = DScale; den_sel = uu_q; gen_sel = 1'b1;
        launch_bad = !lim_ok(nval) || (uu_q == '0);
      end
      OP_W: begin a_sel = v_q[i_q]; b_sel = d_q; end
      default: ;
    endcase
  end

  assign abs_a = a_sel[63] ? -a_sel : a_sel;
  assign abs_b = b_sel[63] ? -b_sel : b_sel;

  // ---------------- multiply step ----------------
  logic [31:0]  ah, bh;
  logic [63:0]  pp64;
  logic [127:0] part;
  assign ah   = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign bh   = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp64 = ah * bh;
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    part = {64'd0, pp64};
      2'd3:    part = {pp64, 64'd0};
      default: part = {32'd0, pp64, 32'd0};
    endcase
  end

  // ---------------- divide step ----------------
  logic [64:0] rem65, rdiff;
  logic        dge;
  assign rem65 = {rem_q, prod_q[127]};
  assign rdiff = rem65 - {1'b0, den_q};
  assign dge   = (rem65 >= {1'b0, den_q});

  // ---------------- rounding ----------------
  logic [127:0]       sh_f, sh_30;
  logic [61:0]        qlo;
  logic               big, rup, rnd_ovf;
  logic [62:0]        q63;
  logic signed [63:0] qmag, rnd_res;
  assign sh_f  = prod_q >> Fb;
  assign sh_30 = prod_q >> Q30;

  always_comb begin
    if (gen_q) begin
      qlo = prod_q[61:0]; big = |prod_q[127:62]; rup = (rem_q >= (den_q - rem_q));
    end else begin
      unique case (op_q)
        OP_MV, OP_W: begin
          qlo = sh_f[61:0]; big = |sh_f[127:62]; rup = prod_q[Fb-1];
        end
        OP_PP, OP_UP, OP_S2: begin
          qlo = sh_30[61:0]; big = |sh_30[127:62]; rup = prod_q[Q30-1];
        end
        default: begin
          qlo = prod_q[61:0]; big = |prod_q[127:62]; rup = 1'b0;
        end
      endcase
    end
  end

  assign q63     = {1'b0, qlo} + 63'(rup);
  assign rnd_ovf = big || q63[62];
  assign qmag    = $signed({2'b00, q63[61:0]});
  assign rnd_res = neg_q ? -qmag : qmag;

  // ---------------- accumulate / checks ----------------
  logic signed [63:0] post_sum;
  logic               post_bad, miss, v_fit;

  always_comb begin
    post_sum = '0;
    post_bad = 1'b0;
    unique case (op_q)
      OP_MV: post_sum = ((j_q == 2'd0) ? 64'sd0 : v_q[i_q]) + res_q;
      OP_PP: post_sum = ((i_q == 2'd0) ? 64'sd0 : pp_q) + res_q;
      OP_UP: post_sum = ((i_q == 2'd0) ? 64'sd0 : up_q) + res_q;
      OP_UU: post_sum = ((i_q == 2'd0) ? 64'sd0 : uu_q) + res_q;
      OP_S2: post_sum = t_q - res_q;
      OP_W:  post_sum = 64'(pos_q[i_q]) + res_q;
      default: post_sum = res_q;
    endcase
    unique case (op_q)
      OP_MV, OP_PP, OP_UP, OP_UU, OP_S2: post_bad = !lim_ok(post_sum);
      OP_W: post_bad = !lim_ok(post_sum) || !fits_w(res_q, FieldWidth) ||
                       !fits_w(post_sum, FieldWidth) || !fits_w(post_sum, Pw);
      default: post_bad = 1'b0;
    endcase
  end

  assign miss  = post_sum[63] || !up_q[63];
  assign v_fit = fits_w(v_q[0], FieldWidth) && fits_w(v_q[1], FieldWidth) &&
                 fits_w(v_q[2], FieldWidth);

  // sqrt step
  logic [63:0] sq_t;
  logic        sq_ge;
  assign sq_t  = sqr_q + sqb_q;
  assign sq_ge = (rem_q >= sq_t);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && cmd_i == CMD_VIEW) state_d = sinv_q ? S_FIN : S_LAUNCH;
      end
      S_LAUNCH: state_d = launch_bad ? S_FIN : S_MUL;
      S_MUL: begin
        if (cnt_q[1:0] == 2'd3) state_d = gen_q ? S_DIV : S_ROUND;
      end
      S_DIV: begin
        if (cnt_q == 7'd127) state_d = S_ROUND;
      end
      S_ROUND: state_d = rnd_ovf ? S_FIN : S_POST;
      S_POST: begin
        if (post_bad) state_d = S_FIN;
        else if (op_q == OP_S2) state_d = miss ? S_FIN : S_SQRT;
        else if (op_q == OP_W && i_q == 2'd2) state_d = S_FIN;
        else state_d = S_LAUNCH;
      end
      S_SQRT: begin
        if (cnt_q[4:0] == 5'd31) state_d = S_SQEND;
      end
      S_SQEND: state_d = S_LAUNCH;
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      equ_q       <= 23'd6378137;
      pol_q       <= 23'd6356752;
      thr_q       <= 34'sd8589934591;
      sinv_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) pos_q[k] <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_EQ_RADIUS:  equ_q <= cfg_data_i[22:0];
          REG_POL_RADIUS: pol_q <= cfg_data_i[22:0];
          REG_THRESHOLD:  thr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire && cmd_i == CMD_POS) begin
        pos_q[0] <= Pw'(64'(val_x_i));
        pos_q[1] <= Pw'(64'(val_y_i));
        pos_q[2] <= Pw'(64'(val_z_i));
        sinv_q   <= ($signed(Pw'(64'(val_x_i))) >= 64'(thr_q));
      end
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && cmd_i == CMD_ROW && row_i != 2'd3) begin
          rot_q[row_i][0] <= val_x_i[31:0];
          rot_q[row_i][1] <= val_y_i[31:0];
          rot_q[row_i][2] <= val_z_i[31:0];
        end
        if (in_fire && cmd_i == CMD_VIEW) begin
          u_q[0]   <= val_x_i;
          u_q[1]   <= val_y_i;
          u_q[2]   <= val_z_i;
          op_q     <= OP_MV;
          i_q      <= '0;
          j_q      <= '0;
          fin_st_q <= ST_INVALID;
        end
      end
      S_LAUNCH: begin
        ma_q   <= abs_a;
        mb_q   <= abs_b;
        neg_q  <= a_sel[63] ^ b_sel[63];
        gen_q  <= gen_sel;
        den_q  <= den_sel;
        prod_q <= '0;
        cnt_q  <= '0;
      end
      S_MUL: begin
        prod_q <= prod_q + part;
        cnt_q  <= (cnt_q[1:0] == 2'd3) ? 7'd0 : cnt_q + 7'd1;
        rem_q  <= '0;
      end
      S_DIV: begin
        rem_q  <= dge ? rdiff[63:0] : rem65[63:0];
        prod_q <= {prod_q[126:0], dge};
        cnt_q  <= cnt_q + 7'd1;
      end
      S_ROUND: res_q <= rnd_res;
      S_POST: begin
        unique case (op_q)
          OP_MV: begin
            v_q[i_q] <= post_sum;
            if (j_q == 2'd2) op_q <= OP_PS;
            else j_q <= j_q + 2'd1;
          end
          OP_PS: begin ps_q[i_q] <= res_q; op_q <= OP_US; end
          OP_US: begin
            us_q[i_q] <= res_q;
            if (i_q == 2'd2) begin
              i_q <= '0; op_q <= OP_PP;
            end else begin
              i_q <= i_q + 2'd1; j_q <= '0; op_q <= OP_MV;
            end
          end
          OP_PP: begin pp_q <= post_sum; op_q <= OP_UP; end
          OP_UP: begin up_q <= post_sum; op_q <= OP_UU; end
          OP_UU: begin
            uu_q <= post_sum;
            if (i_q == 2'd2) op_q <= OP_S1;
            else begin
              i_q <= i_q + 2'd1; op_q <= OP_PP;
            end
          end
          OP_S1: begin t_q <= res_q; op_q <= OP_S2; end
          OP_S2: begin
            t_q <= post_sum;
            if (miss) begin
              fin_st_q <= v_fit ? ST_NOHIT : ST_INVALID;
              for (int k = 0; k < 3; k++) begin
                w_q[k] <= v_q[k][33:0];
                g_q[k] <= '0;
              end
            end
            rem_q <= post_sum;
            sqr_q <= '0;
            sqb_q <= 64'd1 << 62;
            cnt_q <= '0;
          end
          OP_D: begin d_q <= res_q; i_q <= '0; op_q <= OP_W; end
          OP_W: begin
            w_q[i_q] <= res_q[33:0];
            g_q[i_q] <= post_sum[33:0];
            if (i_q == 2'd2) begin
              if (!post_bad) fin_st_q <= ST_HIT;
            end else i_q <= i_q + 2'd1;
          end
          default: ;
        endcase
      end
      S_SQRT: begin
        rem_q <= sq_ge ? rem_q - sq_t : rem_q;
        sqr_q <= (sqr_q >> 1) + (sq_ge ? sqb_q : 64'd0);
        sqb_q <= sqb_q >> 2;
        cnt_q <= cnt_q + 7'd1;
      end
      S_SQEND: begin
        if (rem_q > sqr_q) sqr_q <= sqr_q + 64'd1;
        op_q <= OP_D;
      end
      S_FIN: begin
        if (out_free) begin
          out_st_q <= fin_st_q;
          for (int k = 0; k < 3; k++) begin
            out_v_q[k] <= (fin_st_q == ST_INVALID) ? '0 : $signed(w_q[k]);
            out_g_q[k] <= (fin_st_q == ST_INVALID) ? '0 : $signed(g_q[k]);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign view_x_o    = out_v_q[0];
  assign view_y_o    = out_v_q[1];
  assign view_z_o    = out_v_q[2];
  assign ground_x_o  = out_g_q[0];
  assign ground_y_o  = out_g_q[1];
  assign ground_z_o  = out_g_q[2];

  // ---------------- assertions ----------------
  `include "view_ray_ellipsoid_intersect_assert.svh"

  `VREI_ASSERT_NOW(a_div_den_nz, clk_i, rst_ni, state_q == S_DIV, den_q != '0)
  `VREI_ASSERT_NOW(a_invalid_zero, clk_i, rst_ni, out_valid_o && status_o == ST_INVALID, (view_x_o == '0) && (view_y_o == '0) && (view_z_o == '0) && (ground_x_o == '0) && (ground_y_o == '0) && (ground_z_o == '0))
  `VREI_ASSERT_NOW(a_nohit_ground, clk_i, rst_ni, out_valid_o && status_o == ST_NOHIT, (ground_x_o == '0) && (ground_y_o == '0) && (ground_z_o == '0))
  `VREI_ASSERT_NEXT(a_fin_loads, clk_i, rst_ni, state_q == S_FIN && out_free, out_valid_o && state_q == S_IDLE)

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for view_ray_ellipsoid_intersect. A directed table of
// items comes first, then random pose/view sequences mixed with noise. Items
// are checked against a bit-true model of the block written in SystemVerilog.
// The bench also runs several radius/threshold settings, among them a zero
// radius and thresholds at both extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import vrei_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CycleLimit = 4_000_000;
  localparam logic signed [33:0] FMax = 34'sh1FFFFFFFF;
  localparam logic signed [33:0] FMin = 34'sh200000000;
  localparam logic signed [33:0] One  = 34'sd1073741824;
  localparam logic signed [63:0] Lim  = 64'sd1 <<< 62;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [33:0] vx, vy, vz, gx, gy, gz;
  } hit_t;

  typedef struct {
    logic [1:0]         cmd, row;
    logic signed [33:0] x, y, z;
    bit                 typed;
    hit_t               res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [33:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [1:0] cmd = '0, row = '0;
  logic signed [33:0] vx_in = '0, vy_in = '0, vz_in = '0;
  logic out_ready = 1'b0;
  wire logic cfg_ready, in_ready, out_valid;
  wire logic [1:0] status;
  wire logic signed [33:0] view_x, view_y, view_z, ground_x, ground_y, ground_z;

  always #5 clk = ~clk;

  view_ray_ellipsoid_intersect dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .row_i(row), .val_x_i(vx_in), .val_y_i(vy_in), .val_z_i(vz_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .view_x_o(view_x), .view_y_o(view_y), .view_z_o(view_z),
    .ground_x_o(ground_x), .ground_y_o(ground_y), .ground_z_o(ground_z)
  );

  // model state
  logic signed [63:0] craft_pos [3];
  logic signed [63:0] rot_mat [9];
  logic signed [63:0] norm_sq;
  logic               pos_invalid;
  logic [63:0]        eq_radius = 64'd6378137;
  logic [63:0]        pol_radius = 64'd6356752;
  logic signed [63:0] threshold = 64'sd8589934591;
  logic               arith_ovf;

  hit_t   pending_hits [$];
  int     errors = 0;
  longint cycles = 0;
  bit     calm = 1'b0;
  real    cur_ang = 0.0;

  // round(a*b/den) half away from zero, flags zero divisor and |q| >= 2^62
  function automatic logic signed [63:0] mul_div(input logic signed [63:0] a, b,
                                                 input logic [63:0] den);
    logic [63:0]  ma, mb;
    logic [127:0] prod, q, r;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    if (den == 0) begin
      arith_ovf = 1'b1;
      return 0;
    end
    prod = {64'd0, ma} * {64'd0, mb};
    q = prod / {64'd0, den};
    r = prod % {64'd0, den};
    if (r >= {64'd0, den} - r) q = q + 1;
    if (q >= (128'd1 << 62)) begin
      arith_ovf = 1'b1;
      return 0;
    end
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic signed [63:0] add_chk(input logic signed [63:0] a, b);
    logic signed [63:0] s;
    s = a + b;
    if (s >= Lim || s <= -Lim) begin
      arith_ovf = 1'b1;
      return 0;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sqrt_round(input logic signed [63:0] sv);
    logic [63:0] s, r, b;
    s = sv;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r = r + 1;
    return r;
  endfunction

  function automatic bit fits34(input logic signed [63:0] x);
    return x >= -(64'sd1 <<< 33) && x < (64'sd1 <<< 33);
  endfunction

  // advances the model by one item; has is set when the item yields a result
  task automatic intersect_item(input logic [1:0] c, r,
                                input logic signed [33:0] x, y, z,
                                output bit has, output hit_t res);
    logic signed [63:0] u [3], v [3], ps [3], us [3], w [3], g [3];
    logic signed [63:0] pp, up, uu, s, n, d, acc;
    logic [63:0]        rad;
    logic [1:0]         st;
    has = 1'b0;
    res = '0;
    case (c)
      CMD_POS: begin
        craft_pos[0] = x;
        craft_pos[1] = y;
        craft_pos[2] = z;
        pos_invalid = craft_pos[0] >= threshold;
      end
      CMD_ROW: begin
        if (r < 3) begin
          rot_mat[r*3]   = $signed(x[31:0]);
          rot_mat[r*3+1] = $signed(y[31:0]);
          rot_mat[r*3+2] = $signed(z[31:0]);
        end
      end
      CMD_VIEW: begin
        has = 1'b1;
        u[0] = x; u[1] = y; u[2] = z;
        for (int i = 0; i < 3; i++) begin
          w[i] = 0;
          g[i] = 0;
        end
        pp = 0; up = 0; uu = 0;
        st = ST_INVALID;
        arith_ovf = 1'b0;
        if (!pos_invalid) begin
          for (int i = 0; i < 3; i++) begin
            rad = i < 2 ? eq_radius : pol_radius;
            acc = 0;
            for (int j = 0; j < 3; j++)
              acc = add_chk(acc, mul_div(rot_mat[i*3+j], u[j], 64'd1 << 30));
            v[i] = acc;
            ps[i] = mul_div(craft_pos[i], 64'sd1 <<< 22, rad);
            us[i] = mul_div(v[i], 64'sd1 <<< 22, rad);
          end
          for (int i = 0; i < 3; i++) begin
            pp = add_chk(pp, mul_div(ps[i], ps[i], 64'd1 << 30));
            up = add_chk(up, mul_div(us[i], ps[i], 64'd1 << 30));
            uu = add_chk(uu, mul_div(us[i], us[i], 64'd1));
          end
          norm_sq = pp;
          s = add_chk(mul_div(up, up, 64'd1),
                      -mul_div(uu, add_chk(pp, -(64'sd1 <<< 30)), 64'd1 << 30));
          if (!arith_ovf) begin
            if (s < 0 || up >= 0) begin
              st = ST_NOHIT;
              for (int i = 0; i < 3; i++) begin
                if (!fits34(v[i])) st = ST_INVALID;
                w[i] = v[i];
              end
            end else begin
              n = add_chk(-up, -sqrt_round(s));
              d = mul_div(n, 64'sd1 <<< 60, uu);
              st = ST_HIT;
              for (int i = 0; i < 3; i++) begin
                w[i] = mul_div(v[i], d, 64'd1 << 30);
                g[i] = add_chk(craft_pos[i], w[i]);
                if (!fits34(w[i]) || !fits34(g[i])) st = ST_INVALID;
              end
              if (arith_ovf) st = ST_INVALID;
            end
          end
        end
        if (st == ST_INVALID) begin
          for (int i = 0; i < 3; i++) begin
            w[i] = 0;
            g[i] = 0;
          end
        end
        res.status = st;
        res.vx = w[0]; res.vy = w[1]; res.vz = w[2];
        res.gx = g[0]; res.gy = g[1]; res.gz = g[2];
      end
      default: ;
    endcase
  endtask

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_item(input logic [1:0] c, r, input logic signed [33:0] x, y, z,
                           input bit typed = 1'b0, input hit_t typed_res = '0);
    bit   has;
    hit_t res;
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    row <= r;
    vx_in <= x;
    vy_in <= y;
    vz_in <= z;
    do @(posedge clk); while (!in_ready);
    intersect_item(c, r, x, y, z, has, res);
    if (has) pending_hits.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [33:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_EQ_RADIUS:  eq_radius = data[22:0];
      REG_POL_RADIUS: pol_radius = data[22:0];
      REG_THRESHOLD:  threshold = $signed(data);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [33:0] eq, pol, thr);
    write_reg(REG_EQ_RADIUS, eq);
    write_reg(REG_POL_RADIUS, pol);
    write_reg(REG_THRESHOLD, thr);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [33:0] q30(input real f);
    longint t;
    t = $rtoi(f * 1073741824.0);
    return t[33:0];
  endfunction

  // spacecraft somewhere in orbit, optional z-rotation matrix, views near nadir
  task automatic pose_sequence(output int count);
    real    rad_m, lon, lat, px, py, pz, nrm, nx, ny, nz, c, s;
    longint t [3];
    int     views;
    rad_m = 6.6e6 + $urandom_range(0, 1400000);
    lon = $urandom_range(0, 62831) / 1.0e4;
    lat = $urandom_range(0, 31415) / 1.0e4 - 1.5708;
    px = rad_m * $cos(lat) * $cos(lon);
    py = rad_m * $cos(lat) * $sin(lon);
    pz = rad_m * $sin(lat);
    t[0] = $rtoi(px * 256.0);
    t[1] = $rtoi(py * 256.0);
    t[2] = $rtoi(pz * 256.0);
    send_item(CMD_POS, 2'd0, t[0][33:0], t[1][33:0], t[2][33:0]);
    count = 1;
    if ($urandom_range(0, 1)) begin
      cur_ang = $urandom_range(0, 62831) / 1.0e4;
      c = $cos(cur_ang);
      s = $sin(cur_ang);
      send_item(CMD_ROW, 2'd0, q30(c), q30(-s), 34'sd0);
      send_item(CMD_ROW, 2'd1, q30(s), q30(c), 34'sd0);
      send_item(CMD_ROW, 2'd2, 34'sd0, 34'sd0, One);
      count += 3;
    end
    c = $cos(cur_ang);
    s = $sin(cur_ang);
    nrm = $sqrt(px*px + py*py + pz*pz);
    views = $urandom_range(2, 6);
    for (int k = 0; k < views; k++) begin
      nx = -px / nrm + ($urandom_range(0, 700) - 350) / 1000.0;
      ny = -py / nrm + ($urandom_range(0, 700) - 350) / 1000.0;
      nz = -pz / nrm + ($urandom_range(0, 700) - 350) / 1000.0;
      send_item(CMD_VIEW, 2'd0, q30(c*nx + s*ny), q30(-s*nx + c*ny), q30(nz));
    end
    count += views;
  endtask

  task automatic random_items(input int total, input bit mid_pause);
    int sent, n;
    logic [63:0] a, b, e;
    sent = 0;
    while (sent < total) begin
      if ($urandom_range(0, 99) < 15) begin
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        e = {$urandom, $urandom};
        send_item($urandom_range(0, 3), $urandom_range(0, 3), a[33:0], b[33:0], e[33:0]);
        sent++;
      end else begin
        pose_sequence(n);
        sent += n;
      end
      if (mid_pause && sent >= total / 2) begin
        mid_pause = 1'b0;
        drain();
      end
    end
  endtask

  stim_row_t dir_tab [$];

  initial begin
    hit_t nohit_up, nohit_down, nohit_zero, bad;
    nohit_up = '{ST_NOHIT, One, 0, 0, 0, 0, 0};
    nohit_down = '{ST_NOHIT, 0, 0, -One, 0, 0, 0};
    nohit_zero = '{ST_NOHIT, 0, 0, 0, 0, 0, 0};
    bad = '{ST_INVALID, 0, 0, 0, 0, 0, 0};
    dir_tab = '{
      '{CMD_ROW, 2'd0, One, 0, 0, 0, '0},
      '{CMD_ROW, 2'd1, 0, One, 0, 0, '0},
      '{CMD_ROW, 2'd2, 0, 0, One, 0, '0},
      '{CMD_ROW, 2'd3, FMax, FMin, FMax, 0, '0},       // bad row, ignored
      '{2'd3, 2'd3, FMin, FMax, FMin, 0, '0},           // bad command, ignored
      '{CMD_POS, 2'd0, 34'sd1792000000, 0, 0, 0, '0},
      '{CMD_VIEW, 2'd0, -One, 0, 0, 0, '0},
      '{CMD_VIEW, 2'd0, One, 0, 0, 1, nohit_up},
      '{CMD_VIEW, 2'd0, 0, 0, 0, 1, nohit_zero},
      '{CMD_VIEW, 2'd0, FMax, FMax, FMax, 1, bad},
      '{CMD_VIEW, 2'd0, FMin, FMin, FMin, 1, bad},
      '{CMD_VIEW, 2'd0, -34'sd700000000, 34'sd300000000, 34'sd150000000, 0, '0},
      '{CMD_POS, 2'd0, 0, 0, 0, 0, '0},
      '{CMD_VIEW, 2'd0, 0, 0, -One, 1, nohit_down},
      '{CMD_POS, 2'd0, 34'sd256000000, 34'sd1000, -34'sd1000, 0, '0},  // inside
      '{CMD_VIEW, 2'd0, -One, 0, 0, 0, '0},
      // upper bits beyond the 32-bit matrix entry are dropped
      '{CMD_ROW, 2'd0, 34'sh340000000, 34'sh200000000, 34'sh1FFFFFFFF, 0, '0},
      '{CMD_POS, 2'd0, FMin, 0, 0, 0, '0},
      '{CMD_VIEW, 2'd0, One, 0, 0, 0, '0},
      '{CMD_ROW, 2'd0, One, 0, 0, 0, '0},
      '{CMD_POS, 2'd0, FMax, FMax, FMax, 0, '0},         // sentinel position
      '{CMD_VIEW, 2'd0, -One, 0, 0, 1, bad}
    };
    for (int i = 0; i < 3; i++) craft_pos[i] = 0;
    for (int i = 0; i < 9; i++) rot_mat[i] = 0;
    norm_sq = 0;
    pos_invalid = 1'b0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i])
      send_item(dir_tab[i].cmd, dir_tab[i].row, dir_tab[i].x, dir_tab[i].y,
                dir_tab[i].z, dir_tab[i].typed, dir_tab[i].res);
    random_items(140, 1'b1);
    drain();

    calm = 1'b1;
    set_regs(34'd7000000, 34'd6000000, 34'd2147483648);
    random_items(140, 1'b0);
    drain();
    calm = 1'b0;

    // every position is at or above the lowest threshold
    set_regs(34'd6000000, 34'd7000000, FMin);
    random_items(20, 1'b0);
    drain();

    set_regs(34'd0, 34'h7FFFFF, FMax);
    random_items(20, 1'b0);
    drain();

    set_regs($urandom_range(6000000, 7000000), $urandom_range(6000000, 7000000),
             34'd1900000000);
    random_items(160, 1'b0);
    drain();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    hit_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{status, view_x, view_y, view_z, ground_x, ground_y, ground_z};
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected item, got %p", $time, got);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz) begin
          $display("%0t: view exp %0d %0d %0d got %0d %0d %0d", $time,
                   want.vx, want.vy, want.vz, got.vx, got.vy, got.vz);
          errors++;
        end
        if (got.gx !== want.gx || got.gy !== want.gy || got.gz !== want.gz) begin
          $display("%0t: ground exp %0d %0d %0d got %0d %0d %0d", $time,
                   want.gx, want.gy, want.gz, got.gx, got.gy, got.gz);
          errors++;
        end
      end
    end
  end

endmodule

`default_nettype wire
